// File: sv/tdt_pkg.sv
// Package with shared constants and register codes of the triangle wave block.
`timescale 1ns / 1ps
package tdt_pkg;

  // Fixed point one in Q16.16.
  localparam logic [30:0] Q_ONE = 31'd65536;

  // Field widths.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned EDGE_W = 31;
  localparam int unsigned IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_AMPLITUDE   = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_DEAD_TIME   = 3'd2,
    REG_RISE_LENGTH = 3'd3,
    REG_FALL_LENGTH = 3'd4,
    REG_PHASE_SHIFT = 3'd5
  } reg_index_t;

endpackage

// File: sv/tdt_div_cell.sv
// One restoring division cell: one quotient bit per cell, registered.
`timescale 1ns / 1ps
module tdt_div_cell #(
  parameter int unsigned RW = 31,
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 31,
  parameter int unsigned SW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] in_rem,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RW-1:0] out_rem,
  output logic [NW-1:0] out_num,
  output logic [DW-1:0] out_den,
  output logic [SW-1:0] out_side
);

  logic [RW:0] trial;
  logic [RW:0] den_ext;
  logic [RW:0] diff;
  logic        ge;

  // Shift in the next numerator bit and try to subtract the divisor.
  assign trial   = {in_rem, in_num[NW-1]};
  assign den_ext = {{(RW+1-DW){1'b0}}, in_den};
  assign diff    = trial - den_ext;
  assign ge      = (trial >= den_ext);

  // Valid bit of the cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Payload hand-off to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= ge ? diff[RW-1:0] : trial[RW-1:0];
      out_num  <= {in_num[NW-2:0], ge};
      out_den  <= in_den;
      out_side <= in_side;
    end
  end

endmodule

// File: sv/tdt_div_chain.sv
// Row of division cells, one per numerator bit, yielding quotient and remainder.
`timescale 1ns / 1ps
module tdt_div_chain #(
  parameter int unsigned RW = 31,
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 31,
  parameter int unsigned SW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RW-1:0] out_rem,
  output logic [NW-1:0] out_quot,
  output logic [DW-1:0] out_den,
  output logic [SW-1:0] out_side
);

  logic          v [0:NW];
  logic [RW-1:0] r [0:NW];
  logic [NW-1:0] n [0:NW];
  logic [DW-1:0] d [0:NW];
  logic [SW-1:0] s [0:NW];

  // Head of the row starts with a zero remainder.
  assign v[0] = in_valid;
  assign r[0] = '0;
  assign n[0] = in_num;
  assign d[0] = in_den;
  assign s[0] = in_side;

  // Cells, each handing its partial result to the next.
  for (genvar i = 0; i < NW; i++) begin : g_cell
    tdt_div_cell #(.RW(RW), .NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v[i]),
      .in_rem   (r[i]),
      .in_num   (n[i]),
      .in_den   (d[i]),
      .in_side  (s[i]),
      .out_valid(v[i+1]),
      .out_rem  (r[i+1]),
      .out_num  (n[i+1]),
      .out_den  (d[i+1]),
      .out_side (s[i+1])
    );
  end

  assign out_valid = v[NW];
  assign out_rem   = r[NW];
  assign out_quot  = n[NW];
  assign out_den   = d[NW];
  assign out_side  = s[NW];

endmodule

// File: sv/triangle_wave_with_dead_time_top.sv
// Top level of the asymmetric triangle wave generator with dead time.
//
// Usage: time points enter as signed Q16.16 words on the s_axis channel
// (s_tdata). Each yields one sample word on the m_axis channel: m_tdata
// holds the saturated Q16.16 sample, m_tuser the saturation flag.
// Configuration is written through cfg_we, cfg_index and cfg_data while
// the block is idle; edge lengths of zero are stored as 1.0.
// The path holds one input register, 33 modulo cells, registers for
// region select, multiply and magnitude, 64 division cells and the
// output register. Throughput is one word per cycle while not stalled;
// the division pipeline takes a new word every unstalled cycle.
// When the receiver stalls, the whole pipeline holds and s_tready drops
// only while the output register keeps an untaken word. Reset clears all
// valid bits and loads the register reset values.
`timescale 1ns / 1ps
module triangle_wave_with_dead_time_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tdt_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tdt_pkg::DATA_W-1:0]  cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [tdt_pkg::DATA_W-1:0]  s_tdata,   // [31:0] time_point
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tdt_pkg::DATA_W-1:0]  m_tdata,   // [31:0] sample
  output logic                        m_tuser    // [0] saturated
);
  import tdt_pkg::*;

  logic signed [31:0] amplitude;
  logic signed [31:0] offset;
  logic [30:0]        dead_time;
  logic [30:0]        rise_length;
  logic [30:0]        fall_length;
  logic signed [31:0] phase_shift;

  logic adv;
  logic [30:0] cfg_edge;

  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign cfg_edge = (cfg_data[30:0] == 31'd0) ? Q_ONE : cfg_data[30:0];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude   <= 32'sd65536;
      offset      <= '0;
      dead_time   <= '0;
      rise_length <= Q_ONE;
      fall_length <= Q_ONE;
      phase_shift <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AMPLITUDE:   amplitude   <= cfg_data;
        REG_OFFSET:      offset      <= cfg_data;
        REG_DEAD_TIME:   dead_time   <= cfg_data[30:0];
        REG_RISE_LENGTH: rise_length <= cfg_edge;
        REG_FALL_LENGTH: fall_length <= cfg_edge;
        REG_PHASE_SHIFT: phase_shift <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [32:0] period;
  logic [32:0] rf_sum;
  assign period = {2'b00, rise_length} + {2'b00, fall_length} + {2'b00, dead_time};
  assign rf_sum = {2'b00, rise_length} + {2'b00, fall_length};

  // Input stage: time difference, sign and magnitude.
  logic [32:0] t_diff;
  logic        v0;
  logic [32:0] mag0;
  logic        neg0;
  assign t_diff = {s_tdata[31], s_tdata} - {phase_shift[31], phase_shift};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg0 <= t_diff[32];
      mag0 <= t_diff[32] ? (33'd0 - t_diff) : t_diff;
    end
  end

  // Modulo over the period.
  logic        vm;
  logic [32:0] rem_m;
  logic [32:0] quot_m;
  logic [32:0] per_m;
  logic        neg_m;

  tdt_div_chain #(.RW(33), .NW(33), .DW(33), .SW(1)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v0),
    .in_num   (mag0),
    .in_den   (period),
    .in_side  (neg0),
    .out_valid(vm),
    .out_rem  (rem_m),
    .out_quot (quot_m),
    .out_den  (per_m),
    .out_side (neg_m)
  );

  // Floor correction and region select.
  logic [32:0] pos;
  logic [32:0] m_sel;
  logic [30:0] d_sel;
  logic        dead_sel;
  assign pos = (neg_m && (rem_m != 33'd0)) ? (per_m - rem_m) : rem_m;

  always_comb begin
    if (pos <= {2'b00, rise_length}) begin
      m_sel = pos;
      d_sel = rise_length;
      dead_sel = 1'b0;
    end else if (pos <= rf_sum) begin
      m_sel = rf_sum - pos;
      d_sel = fall_length;
      dead_sel = 1'b0;
    end else begin
      m_sel = '0;
      d_sel = rise_length;
      dead_sel = 1'b1;
    end
  end

  logic        v1, v2, v3;
  logic [32:0] m1;
  logic [30:0] d1, d2, d3;
  logic        dead1, dead2, dead3;
  logic signed [65:0] prod2;
  logic        sign3;
  logic [63:0] mag3;
  logic [65:0] prod_neg;
  assign prod_neg = 66'd0 - prod2;

  // Valid bits of the select, multiply and magnitude stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= vm;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Select, multiply and magnitude stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      m1    <= m_sel;
      d1    <= d_sel;
      dead1 <= dead_sel;
      prod2 <= $signed({1'b0, m1}) * amplitude;
      d2    <= d1;
      dead2 <= dead1;
      sign3 <= prod2[65];
      mag3  <= prod2[65] ? prod_neg[63:0] : prod2[63:0];
      d3    <= d2;
      dead3 <= dead2;
    end
  end

  // Division of the product by the edge length.
  logic        vq;
  logic [30:0] rem_q;
  logic [63:0] quot_q;
  logic [30:0] den_q;
  logic [1:0]  side_q;

  tdt_div_chain #(.RW(31), .NW(64), .DW(31), .SW(2)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v3),
    .in_num   (mag3),
    .in_den   (d3),
    .in_side  ({sign3, dead3}),
    .out_valid(vq),
    .out_rem  (rem_q),
    .out_quot (quot_q),
    .out_den  (den_q),
    .out_side (side_q)
  );

  // Sign restore, offset add and saturation.
  logic signed [65:0] q_s;
  logic signed [65:0] off_s;
  logic signed [65:0] sum;
  logic [31:0]        smp;
  logic               sat;
  assign q_s   = side_q[1] ? $signed(66'd0 - {2'b00, quot_q}) : $signed({2'b00, quot_q});
  assign off_s = {{34{offset[31]}}, offset};

  always_comb begin
    sum = side_q[0] ? off_s : (q_s + off_s);
    if (sum > 66'sd2147483647) begin
      smp = 32'h7FFF_FFFF;
      sat = 1'b1;
    end else if (sum < -66'sd2147483648) begin
      smp = 32'h8000_0000;
      sat = 1'b1;
    end else begin
      smp = sum[31:0];
      sat = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= smp;
      m_tuser <= sat;
    end
  end

endmodule

// File: dv/triangle_wave_with_dead_time_top_tb.sv
// Self-checking testbench of the triangle wave generator with dead time.
`timescale 1ns / 1ps
module triangle_wave_with_dead_time_top_tb;
  import tdt_pkg::*;

  localparam int unsigned LATENCY = 102;
  localparam int unsigned RANDOM_ITEMS = 1650;

  typedef struct packed {
    logic [31:0] sample;
    logic        saturated;
  } wave_out_t;

  typedef struct {
    logic [31:0] time_point;
    logic        has_expected;
    logic [31:0] sample;
    logic        saturated;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic m_tuser;

  // Shadow copy of the configuration registers.
  logic signed [63:0] amp_q, offs_q, dead_q, rise_q, fall_q, shift_q;

  wave_out_t expected_samples[$];
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned saturated_seen = 0;
  int unsigned cfg_settings = 0;
  bit no_idle_in = 1'b0;
  bit no_idle_out = 1'b0;
  bit hold_sink = 1'b0;

  triangle_wave_with_dead_time_top DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  // Predict one sample from a time point and the shadow registers.
  function automatic wave_out_t wave_at(logic [31:0] tp);
    logic signed [63:0] t, period, pos, v;
    wave_out_t r;
    t = 64'(signed'(tp)) - shift_q;
    period = rise_q + fall_q + dead_q;
    pos = t % period;
    if (pos < 0) pos += period;
    if (pos <= rise_q) v = (pos * amp_q) / rise_q + offs_q;
    else if (pos <= rise_q + fall_q) v = ((rise_q + fall_q - pos) * amp_q) / fall_q + offs_q;
    else v = offs_q;
    r.saturated = 1'b0;
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      r.saturated = 1'b1;
    end else if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      r.saturated = 1'b1;
    end
    r.sample = v[31:0];
    return r;
  endfunction

  // Write one register and update the shadow copy; block must be idle.
  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_AMPLITUDE: amp_q = 64'(signed'(val));
      REG_OFFSET: offs_q = 64'(signed'(val));
      REG_DEAD_TIME: dead_q = {33'd0, val[30:0]};
      REG_RISE_LENGTH: rise_q = (val[30:0] == 0) ? 64'(Q_ONE) : {33'd0, val[30:0]};
      REG_FALL_LENGTH: fall_q = (val[30:0] == 0) ? 64'(Q_ONE) : {33'd0, val[30:0]};
      REG_PHASE_SHIFT: shift_q = 64'(signed'(val));
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one time point with random idling and wait for acceptance.
  task automatic send_time(logic [31:0] tp, bit idle_ok);
    while (idle_ok && !no_idle_in && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= tp;
    expected_samples.push_back(wave_at(tp));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_all();
    s_tvalid <= 1'b0;
    wait (expected_samples.size() == 0);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0004_0000);
      3: return -$urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  // Sink: random idling, one long hold when asked.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_sink) m_tready <= 1'b0;
    else m_tready <= no_idle_out || ($urandom_range(99) >= 25);
  end

  // Compare each output word with the oldest expectation.
  always @(posedge clk) begin
    wave_out_t got, exp_s;
    if (!rst && m_tvalid && m_tready) begin
      got.sample = m_tdata;
      got.saturated = m_tuser;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word: sample %h sat %b", m_tdata, m_tuser);
      end else begin
        exp_s = expected_samples.pop_front();
        words_checked++;
        if (got.saturated) saturated_seen++;
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected sample %h sat %b, got sample %h sat %b",
                     exp_s.sample, exp_s.saturated, got.sample, got.saturated);
        end
      end
    end
  end

  // Hold off the sink for a long stretch while the source keeps offering.
  task automatic long_hold();
    int unsigned n;
    hold_sink = 1'b1;
    for (n = 0; n < 300; n++) @(negedge clk);
    hold_sink = 1'b0;
  endtask

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    int unsigned i, phase;
    amp_q = 64'sd65536; offs_q = 0; dead_q = 0;
    rise_q = 64'sd65536; fall_q = 64'sd65536; shift_q = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table at reset settings: period 2.0, peak 1.0.
    rows.push_back('{32'h0000_0000, 1, 32'h0000_0000, 0});
    rows.push_back('{32'h0000_8000, 1, 32'h0000_8000, 0});
    rows.push_back('{32'h0001_0000, 1, 32'h0001_0000, 0});
    rows.push_back('{32'h0001_8000, 1, 32'h0000_8000, 0});
    rows.push_back('{32'h0002_0000, 1, 32'h0000_0000, 0});
    rows.push_back('{32'hFFFF_8000, 1, 32'h0000_8000, 0});
    rows.push_back('{32'h7FFF_FFFF, 0, 0, 0});
    rows.push_back('{32'h8000_0000, 0, 0, 0});
    rows.push_back('{32'hFFFF_FFFF, 0, 0, 0});
    foreach (rows[k]) begin
      row = rows[k];
      if (row.has_expected && wave_at(row.time_point) !== {row.sample, row.saturated}) begin
        mismatches++;
        $display("Table row %0d disagrees with predictor", k);
      end
      send_time(row.time_point, 1'b1);
    end
    drain_all();

    // Directed extremes: saturation, zero edges, dead time, phase.
    write_reg(REG_AMPLITUDE, 32'h7FFF_FFFF);
    write_reg(REG_OFFSET, 32'h7FFF_0000);
    write_reg(REG_DEAD_TIME, 32'hFFFF_FFFF);
    write_reg(REG_RISE_LENGTH, 32'h8000_0000);
    write_reg(REG_FALL_LENGTH, 32'h0000_0001);
    write_reg(REG_PHASE_SHIFT, 32'h8000_0000);
    write_reg(reg_index_t'(3'd7), 32'h1234_5678);
    cfg_settings++;
    foreach (rows[k]) send_time(rows[k].time_point, 1'b0);
    send_time(32'h8001_0000, 1'b0);
    send_time(32'h8000_0001, 1'b0);
    drain_all();
    write_reg(REG_AMPLITUDE, 32'h8000_0000);
    write_reg(REG_OFFSET, 32'h8000_0000);
    write_reg(REG_DEAD_TIME, 32'h0000_0000);
    write_reg(REG_RISE_LENGTH, 32'h7FFF_FFFF);
    write_reg(REG_FALL_LENGTH, 32'h7FFF_FFFF);
    write_reg(REG_PHASE_SHIFT, 32'h7FFF_FFFF);
    cfg_settings++;
    foreach (rows[k]) send_time(rows[k].time_point, 1'b0);
    drain_all();

    // Random phases, each with its own register setting.
    for (phase = 0; phase < 11; phase++) begin
      write_reg(REG_AMPLITUDE, rand_word());
      write_reg(REG_OFFSET, rand_word());
      write_reg(REG_DEAD_TIME, ($urandom_range(2) == 0) ? 32'd0 : rand_word());
      write_reg(REG_RISE_LENGTH, ($urandom_range(5) == 0) ? 32'd0 : rand_word());
      write_reg(REG_FALL_LENGTH, ($urandom_range(5) == 0) ? 32'd0 : rand_word());
      write_reg(REG_PHASE_SHIFT, rand_word());
      cfg_settings++;
      no_idle_in = (phase == 3);
      no_idle_out = (phase == 3);
      if (phase == 5) fork long_hold(); join_none
      for (i = 0; i < RANDOM_ITEMS / 11; i++) begin
        send_time(rand_word(), 1'b1);
        if (phase == 7 && i == 60) begin
          s_tvalid <= 1'b0;
          wait (expected_samples.size() == 0);
          @(negedge clk);
        end
      end
      drain_all();
    end

    $display("Checked %0d samples (%0d saturated) over %0d register settings.",
             words_checked, saturated_seen, cfg_settings);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("Timeout with %0d words outstanding", expected_samples.size());
    $display("FAILURE");
    $finish;
  end
endmodule
